// ===== hw/rtl/xppd_pkg.sv =====
// xppd_pkg: types and constants of the packed pattern decoder
// no dependencies; used by the channel interfaces and xm_packed_pattern_decoder

package xppd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 6;
    localparam int CHANNEL_W  = 5;
    localparam int ROW_W      = 8;
    localparam int NUM_FIELDS = 5;

    localparam int DEFAULT_MAX_CHANNELS = 32;
    localparam int DEFAULT_MAX_ROWS     = 256;

    localparam logic [CFG_W-1:0] CHANNEL_COUNT_RESET = 6'd4;

    localparam int FLAG_BIT     = 7;
    localparam int FIELD_NOTE   = 0;
    localparam int FIELD_INSTR  = 1;
    localparam int FIELD_VOLUME = 2;
    localparam int FIELD_EFFECT = 3;
    localparam int FIELD_PARAM  = 4;

    localparam logic [NUM_FIELDS-1:0] UNPACKED_MASK = 5'h1E;
    localparam logic [BYTE_W-1:0]     EFFECT_BREAK  = 8'h0D;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TRUNCATED = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef logic [NUM_FIELDS-1:0][BYTE_W-1:0] cell_fields_t;

endpackage

// ===== hw/rtl/xppd_in_if.sv =====
// xppd_in_if: input channel of the decoder, one packed byte per item
// depends on xppd_pkg

interface xppd_in_if;
    logic                      valid;
    logic                      ready;
    logic [xppd_pkg::BYTE_W-1:0] data_byte;
    logic                      end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

// ===== hw/rtl/xppd_out_if.sv =====
// xppd_out_if: output channel of the decoder, one decoded cell per item
// depends on xppd_pkg

interface xppd_out_if;
    logic                           valid;
    logic                           ready;
    logic [xppd_pkg::BYTE_W-1:0]    note;
    logic [xppd_pkg::BYTE_W-1:0]    instrument;
    logic [xppd_pkg::BYTE_W-1:0]    volume;
    logic [xppd_pkg::BYTE_W-1:0]    effect;
    logic [xppd_pkg::BYTE_W-1:0]    param;
    logic [xppd_pkg::CHANNEL_W-1:0] channel;
    logic [xppd_pkg::ROW_W-1:0]     row;
    logic                           last_of_pattern;
    xppd_pkg::status_t              status;

    modport source (output valid, output note, output instrument, output volume,
                    output effect, output param, output channel, output row,
                    output last_of_pattern, output status, input ready);
    modport sink   (input valid, input note, input instrument, input volume,
                    input effect, input param, input channel, input row,
                    input last_of_pattern, input status, output ready);
endinterface

// ===== hw/rtl/xm_packed_pattern_decoder.sv =====
// xm_packed_pattern_decoder: packed pattern bytes in, decoded cells out
// depends on xppd_pkg, xppd_in_if, xppd_out_if
//
// channel    direction  handshake      content
// byte_in    in         valid/ready    data_byte, end_of_data
// cell_out   out        valid/ready    note..param, channel, row, last_of_pattern, status
// cfg        in         cfg_wr_en      cfg_wr_data: channel_count
//
// one byte accepted per cycle while the result is not stalled; a cell is registered once the step takes its last byte
// the input register feeds one decode step into the result register
// a stalled result holds the decode step; one more byte is held in the input register
// reset clears all decode state and sets channel_count to 4

module xm_packed_pattern_decoder #(
    parameter int MAX_CHANNELS = xppd_pkg::DEFAULT_MAX_CHANNELS,
    parameter int MAX_ROWS     = xppd_pkg::DEFAULT_MAX_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [xppd_pkg::CFG_W-1:0]  cfg_wr_data,
    xppd_in_if.sink                     byte_in,
    xppd_out_if.source                  cell_out
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [6:0] MAX_CH_V = 7'(MAX_CHANNELS);
    localparam logic [xppd_pkg::ROW_W-1:0] LAST_ROW = xppd_pkg::ROW_W'(MAX_ROWS - 1);

    logic [xppd_pkg::CFG_W-1:0]  channel_count_reg;

    logic                        in_valid_reg;
    logic [xppd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_eod_reg;

    logic [CH_W-1:0]                   channel_index_reg, channel_index_next;
    logic [xppd_pkg::ROW_W-1:0]        row_index_reg, row_index_next;
    logic [xppd_pkg::NUM_FIELDS-1:0]   pending_reg, pending_next;
    xppd_pkg::cell_fields_t            fields_reg, fields_next;
    logic                              break_seen_reg, break_seen_next;
    logic                              done_reg, done_next;
    logic                              overflowed_reg, overflowed_next;

    logic                              out_valid_reg;
    xppd_pkg::cell_fields_t            out_fields_reg, out_fields_next;
    logic [xppd_pkg::CHANNEL_W-1:0]    out_channel_reg, out_channel_next;
    logic [xppd_pkg::ROW_W-1:0]        out_row_reg, out_row_next;
    logic                              out_last_reg, out_last_next;
    xppd_pkg::status_t                 out_status_reg, out_status_next;

    logic                              advance;
    logic                              emit;
    logic                              complete;
    logic [xppd_pkg::NUM_FIELDS-1:0]   pend_step;
    logic [xppd_pkg::NUM_FIELDS-1:0]   low_bit;
    xppd_pkg::cell_fields_t            step_fields;
    logic [6:0]                        eff_channels;
    logic [CH_W:0]                     index_inc;
    logic                              row_wrap;
    logic                              break_now;

    assign advance       = in_valid_reg && (!out_valid_reg || cell_out.ready);
    assign byte_in.ready = !in_valid_reg || advance;

    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            eff_channels = 7'd1;
        end
        else if ({1'b0, channel_count_reg} > MAX_CH_V)
        begin
            eff_channels = MAX_CH_V;
        end
        else
        begin
            eff_channels = {1'b0, channel_count_reg};
        end
    end

    // one decode step on the registered byte
    always_comb
    begin
        step_fields = fields_reg;
        low_bit     = pending_reg & (~pending_reg + 1'b1);
        if (pending_reg == '0)
        begin
            if (in_byte_reg[xppd_pkg::FLAG_BIT])
            begin
                step_fields = '0;
                pend_step   = in_byte_reg[xppd_pkg::NUM_FIELDS-1:0];
            end
            else
            begin
                step_fields                       = '0;
                step_fields[xppd_pkg::FIELD_NOTE] = in_byte_reg;
                pend_step                         = xppd_pkg::UNPACKED_MASK;
            end
        end
        else
        begin
            for (int k = 0; k < xppd_pkg::NUM_FIELDS; k++)
            begin
                if (low_bit[k])
                begin
                    step_fields[k] = fields_reg[k] | in_byte_reg;
                end
            end
            pend_step = pending_reg & (pending_reg - 1'b1);
        end
    end

    assign complete  = (pend_step == '0);
    assign emit      = !done_reg && (complete || in_eod_reg);
    assign index_inc = {1'b0, channel_index_reg} + 1'b1;
    assign row_wrap  = (8'(index_inc) >= {1'b0, eff_channels});
    assign break_now = break_seen_reg
                    || (step_fields[xppd_pkg::FIELD_EFFECT] == xppd_pkg::EFFECT_BREAK);

    always_comb
    begin
        channel_index_next = channel_index_reg;
        row_index_next     = row_index_reg;
        pending_next       = pend_step;
        fields_next        = step_fields;
        break_seen_next    = break_seen_reg;
        done_next          = done_reg;
        overflowed_next    = overflowed_reg;
        out_last_next      = 1'b0;
        out_fields_next    = step_fields;
        out_channel_next   = xppd_pkg::CHANNEL_W'({5'd0, channel_index_reg});
        out_row_next       = row_index_reg;

        if (!complete)
        begin
            out_status_next = xppd_pkg::STATUS_TRUNCATED;
        end
        else if (overflowed_reg)
        begin
            out_status_next = xppd_pkg::STATUS_OVERFLOW;
        end
        else
        begin
            out_status_next = xppd_pkg::STATUS_OK;
        end

        if (done_reg)
        begin
            pending_next = pending_reg;
            fields_next  = fields_reg;
        end
        else if (complete)
        begin
            break_seen_next = break_now;
            fields_next     = '0;
            if (row_wrap)
            begin
                channel_index_next = '0;
                if (row_index_reg >= LAST_ROW)
                begin
                    row_index_next  = LAST_ROW;
                    overflowed_next = 1'b1;
                end
                else
                begin
                    row_index_next = row_index_reg + 1'b1;
                end
                if (break_now)
                begin
                    out_last_next = 1'b1;
                    done_next     = 1'b1;
                end
                break_seen_next = 1'b0;
            end
            else
            begin
                channel_index_next = index_inc[CH_W-1:0];
            end
        end

        // end of data starts the next pattern
        if (in_eod_reg)
        begin
            out_last_next      = 1'b1;
            channel_index_next = '0;
            row_index_next     = '0;
            pending_next       = '0;
            fields_next        = '0;
            break_seen_next    = 1'b0;
            done_next          = 1'b0;
            overflowed_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= xppd_pkg::CHANNEL_COUNT_RESET;
            in_valid_reg      <= 1'b0;
            channel_index_reg <= '0;
            row_index_reg     <= '0;
            pending_reg       <= '0;
            fields_reg        <= '0;
            break_seen_reg    <= 1'b0;
            done_reg          <= 1'b0;
            overflowed_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                channel_count_reg <= cfg_wr_data;
            end

            if (byte_in.valid && byte_in.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                channel_index_reg <= channel_index_next;
                row_index_reg     <= row_index_next;
                pending_reg       <= pending_next;
                fields_reg        <= fields_next;
                break_seen_reg    <= break_seen_next;
                done_reg          <= done_next;
                overflowed_reg    <= overflowed_next;
                out_valid_reg     <= emit;
            end
            else if (cell_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg <= byte_in.data_byte;
            in_eod_reg  <= byte_in.end_of_data;
        end
        if (advance && emit)
        begin
            out_fields_reg  <= out_fields_next;
            out_channel_reg <= out_channel_next;
            out_row_reg     <= out_row_next;
            out_last_reg    <= out_last_next;
            out_status_reg  <= out_status_next;
        end
    end

    assign cell_out.valid           = out_valid_reg;
    assign cell_out.note            = out_fields_reg[xppd_pkg::FIELD_NOTE];
    assign cell_out.instrument      = out_fields_reg[xppd_pkg::FIELD_INSTR];
    assign cell_out.volume          = out_fields_reg[xppd_pkg::FIELD_VOLUME];
    assign cell_out.effect          = out_fields_reg[xppd_pkg::FIELD_EFFECT];
    assign cell_out.param           = out_fields_reg[xppd_pkg::FIELD_PARAM];
    assign cell_out.channel         = out_channel_reg;
    assign cell_out.row             = out_row_reg;
    assign cell_out.last_of_pattern = out_last_reg;
    assign cell_out.status          = out_status_reg;

    a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_out.valid && cell_out.status == xppd_pkg::STATUS_TRUNCATED)
            |-> cell_out.last_of_pattern)
        else $error("truncated cell without last_of_pattern");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !emit)
        else $error("cell emitted after pattern break");

    a_overflow_row: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> (row_index_reg == LAST_ROW))
        else $error("overflow flagged below last row");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (8'(channel_index_reg) < 8'(MAX_CHANNELS)))
        else $error("channel index out of range");

    a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held byte lost while result stalled");

endmodule
